// File: hdl/kspa_pkg.sv
// Package of shared types, codes and sizes for the sort key padding assembler.
package kspa_pkg;

    // Default key store depth and the derived widths.
    localparam int KSPA_KEY_BYTES = 256;
    localparam int KSPA_LEN_W     = $clog2(KSPA_KEY_BYTES + 1);

    // Operation codes of a request.
    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_PAD   = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_LEX   = 3'd3;
    localparam logic [2:0] OP_CRX   = 3'd4;
    localparam logic [2:0] OP_READ  = 3'd5;

    // Status codes of a result.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_LEX = 2'd1;
    localparam logic [1:0] ST_NO_CRX = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    // Pad byte values.
    localparam logic [7:0] PAD_HALF  = 8'd240;
    localparam logic [7:0] PAD_LEX   = 8'd255;
    localparam logic [7:0] PAD_CRX   = 8'd0;

    // Functions of the shared byte unit.
    typedef enum logic [2:0] {
        ALU_PASS,
        ALU_OR,
        ALU_SUB16,
        ALU_DEC,
        ALU_INC
    } alu_func_t;

    // Flags the byte unit reports about its stored-byte operand.
    typedef struct packed {
        logic zero;
        logic ones;
        logic below16;
        logic nib15;
    } alu_flags_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_FILL,
        S_MOD,
        S_SPILL,
        S_WALK,
        S_DONE
    } seq_state_t;

endpackage

// File: hdl/kspa_in_if.sv
// Request channel interface of the sort key padding assembler.
interface kspa_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [6:0] lex_count;
    logic [6:0] contrelex_count;
    logic       half_byte;
    logic [6:0] group_offset;
    logic [7:0] data_byte;
    logic [3:0] bit_count;
    logic [2:0] bit_offset;
    logic [7:0] read_index;

    modport source (
        output valid, operation, lex_count, contrelex_count, half_byte,
               group_offset, data_byte, bit_count, bit_offset, read_index,
        input  ready
    );

    modport sink (
        input  valid, operation, lex_count, contrelex_count, half_byte,
               group_offset, data_byte, bit_count, bit_offset, read_index,
        output ready
    );
endinterface

// File: hdl/kspa_out_if.sv
// Result channel interface of the sort key padding assembler.
interface kspa_out_if #(
    parameter int LEN_W = kspa_pkg::KSPA_LEN_W
);
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [LEN_W-1:0] key_length;
    logic [2:0]       next_bit_offset;
    logic [7:0]       read_byte;

    modport source (
        output valid, status, key_length, next_bit_offset, read_byte,
        input  ready
    );

    modport sink (
        input  valid, status, key_length, next_bit_offset, read_byte,
        output ready
    );
endinterface

// File: hdl/kspa_mem.sv
// Key store: one write port and one registered read port.
module kspa_mem #(
    parameter int DEPTH  = kspa_pkg::KSPA_KEY_BYTES,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/kspa_alu.sv
// Shared byte unit: or-in of shifted bits, nibble and byte steps, and flags.
module kspa_alu (
    input  kspa_pkg::alu_func_t  func,
    input  logic [7:0]           stored,
    input  logic [7:0]           data,
    input  logic [2:0]           offset,
    output logic [7:0]           result,
    output logic [7:0]           spill,
    output kspa_pkg::alu_flags_t flags
);

    logic [15:0] spill_wide;

    // Main result selected by the sequencer.
    always_comb
    begin
        case (func)
            kspa_pkg::ALU_OR:    result = stored | (data >> offset);
            kspa_pkg::ALU_SUB16: result = stored - 8'd16;
            kspa_pkg::ALU_DEC:   result = stored - 8'd1;
            kspa_pkg::ALU_INC:   result = stored + 8'd1;
            default:             result = stored;
        endcase
    end

    // The spill byte holds the bits that did not fit in the last key byte.
    assign spill_wide = {data, 8'h00} >> offset;
    assign spill      = spill_wide[7:0];

    // Conditions that stop or reject a borrow or carry.
    assign flags.zero    = (stored == 8'h00);
    assign flags.ones    = (stored == 8'hff);
    assign flags.below16 = (stored[7:4] == 4'h0);
    assign flags.nib15   = (stored[3:0] == 4'hf);

endmodule

// File: hdl/kspa_seq.sv
// Sequencer: decodes a request and steps the key store one byte per cycle.
module kspa_seq #(
    parameter int KEY_BYTES = kspa_pkg::KSPA_KEY_BYTES,
    parameter int ADDR_W    = $clog2(KEY_BYTES),
    parameter int SIZE_W    = $clog2(KEY_BYTES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    kspa_in_if.sink              items,
    kspa_out_if.source           results,
    // Key store port.
    output logic                 mem_we,
    output logic [ADDR_W-1:0]    mem_waddr,
    output logic [7:0]           mem_wdata,
    output logic [ADDR_W-1:0]    mem_raddr,
    input  logic [7:0]           mem_rdata,
    // Shared byte unit.
    output kspa_pkg::alu_func_t  alu_func,
    output logic [7:0]           alu_data,
    output logic [2:0]           alu_offset,
    input  logic [7:0]           alu_result,
    input  logic [7:0]           alu_spill,
    input  kspa_pkg::alu_flags_t alu_flags
);

    localparam int CW = SIZE_W + 8;
    localparam logic [CW-1:0] KEY_CW = CW'(KEY_BYTES);

    kspa_pkg::seq_state_t state_reg, state_next;

    // Latched request fields.
    logic [2:0] op_reg,    op_next;
    logic [6:0] lex_reg,   lex_next;
    logic [6:0] crx_reg,   crx_next;
    logic       half_reg,  half_next;
    logic [6:0] group_reg, group_next;
    logic [7:0] data_reg,  data_next;
    logic [3:0] cnt_reg,   cnt_next;
    logic [2:0] off_reg,   off_next;
    logic [7:0] ridx_reg,  ridx_next;

    // Working state.
    logic [SIZE_W-1:0] size_reg,   size_next;
    logic [ADDR_W-1:0] ptr_reg,    ptr_next;
    logic [6:0]        walk_reg,   walk_next;
    logic [1:0]        status_reg, status_next;
    logic [2:0]        nbo_reg,    nbo_next;
    logic [7:0]        rbyte_reg,  rbyte_next;

    // Result register.
    logic              ovalid_reg,  ovalid_next;
    logic [1:0]        ostatus_reg, ostatus_next;
    logic [SIZE_W-1:0] olen_reg,    olen_next;
    logic [2:0]        onbo_reg,    onbo_next;
    logic [7:0]        orbyte_reg,  orbyte_next;

    // Derived values.
    logic [SIZE_W-1:0] size_m1;
    logic [SIZE_W-1:0] size_p1;
    logic [CW-1:0]     size_cw;
    logic [CW-1:0]     room_cw;
    logic [CW-1:0]     need_cw;
    logic [CW-1:0]     crx_cw;
    logic [CW-1:0]     ridx_cw;
    logic [CW-1:0]     lex_pos_cw;
    logic [4:0]        bit_end;
    logic              spill_needed;
    logic              size_full;
    logic              size_empty;
    logic              is_lex;
    logic              accept;

    assign size_m1      = size_reg - SIZE_W'(1);
    assign size_p1      = size_reg + SIZE_W'(1);
    assign size_cw      = {8'h00, size_reg};
    assign room_cw      = KEY_CW - size_cw;
    assign need_cw      = {{SIZE_W{1'b0}}, {1'b0, lex_reg} + {1'b0, crx_reg}};
    assign crx_cw       = {{(SIZE_W + 1){1'b0}}, crx_reg};
    assign ridx_cw      = {{SIZE_W{1'b0}}, ridx_reg};
    assign lex_pos_cw   = size_cw - crx_cw - CW'(1);
    assign bit_end      = {2'b00, off_reg} + {1'b0, cnt_reg};
    assign spill_needed = (bit_end > 5'd8);
    assign size_full    = (size_cw >= KEY_CW);
    assign size_empty   = (size_reg == '0);
    assign is_lex       = (op_reg == kspa_pkg::OP_LEX);

    assign items.ready  = (state_reg == kspa_pkg::S_IDLE);
    assign accept       = items.valid && items.ready;

    assign alu_data     = data_reg;
    assign alu_offset   = off_reg;

    assign results.valid           = ovalid_reg;
    assign results.status          = ostatus_reg;
    assign results.key_length      = olen_reg;
    assign results.next_bit_offset = onbo_reg;
    assign results.read_byte       = orbyte_reg;

    // Control and size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= kspa_pkg::S_IDLE;
            size_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            size_reg   <= size_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        lex_reg     <= lex_next;
        crx_reg     <= crx_next;
        half_reg    <= half_next;
        group_reg   <= group_next;
        data_reg    <= data_next;
        cnt_reg     <= cnt_next;
        off_reg     <= off_next;
        ridx_reg    <= ridx_next;
        ptr_reg     <= ptr_next;
        walk_reg    <= walk_next;
        status_reg  <= status_next;
        nbo_reg     <= nbo_next;
        rbyte_reg   <= rbyte_next;
        ostatus_reg <= ostatus_next;
        olen_reg    <= olen_next;
        onbo_reg    <= onbo_next;
        orbyte_reg  <= orbyte_next;
    end

    // Next state and outputs of the sequencer.
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        lex_next     = lex_reg;
        crx_next     = crx_reg;
        half_next    = half_reg;
        group_next   = group_reg;
        data_next    = data_reg;
        cnt_next     = cnt_reg;
        off_next     = off_reg;
        ridx_next    = ridx_reg;
        size_next    = size_reg;
        ptr_next     = ptr_reg;
        walk_next    = walk_reg;
        status_next  = status_reg;
        nbo_next     = nbo_reg;
        rbyte_next   = rbyte_reg;
        ovalid_next  = ovalid_reg;
        ostatus_next = ostatus_reg;
        olen_next    = olen_reg;
        onbo_next    = onbo_reg;
        orbyte_next  = orbyte_reg;
        mem_we       = 1'b0;
        mem_waddr    = ptr_reg;
        mem_wdata    = alu_result;
        mem_raddr    = ptr_reg;
        alu_func     = kspa_pkg::ALU_PASS;

        // A taken result frees the result register.
        if (ovalid_reg && results.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            kspa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = items.operation;
                    lex_next    = items.lex_count;
                    crx_next    = items.contrelex_count;
                    half_next   = items.half_byte;
                    group_next  = items.group_offset;
                    data_next   = items.data_byte;
                    cnt_next    = items.bit_count;
                    off_next    = items.bit_offset;
                    ridx_next   = items.read_index;
                    status_next = kspa_pkg::ST_OK;
                    nbo_next    = 3'd0;
                    rbyte_next  = 8'd0;
                    state_next  = kspa_pkg::S_START;
                end
            end

            kspa_pkg::S_START:
            begin
                state_next = kspa_pkg::S_DONE;
                case (op_reg)
                    kspa_pkg::OP_CLEAR:
                    begin
                        size_next = '0;
                    end

                    kspa_pkg::OP_PAD:
                    begin
                        if (group_reg != 7'd0)
                        begin
                            status_next = kspa_pkg::ST_OK;
                        end
                        else if (half_reg)
                        begin
                            if (size_full)
                            begin
                                status_next = kspa_pkg::ST_RANGE;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = size_reg[ADDR_W-1:0];
                                mem_wdata = kspa_pkg::PAD_HALF;
                                size_next = size_p1;
                            end
                        end
                        else if (need_cw > room_cw)
                        begin
                            status_next = kspa_pkg::ST_RANGE;
                        end
                        else
                        begin
                            state_next = kspa_pkg::S_FILL;
                        end
                    end

                    kspa_pkg::OP_ADD:
                    begin
                        if (off_reg == 3'd0)
                        begin
                            if (size_full)
                            begin
                                status_next = kspa_pkg::ST_RANGE;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = size_reg[ADDR_W-1:0];
                                mem_wdata = data_reg;
                                size_next = size_p1;
                                nbo_next  = bit_end[2:0];
                            end
                        end
                        else if (size_empty || (spill_needed && size_full))
                        begin
                            status_next = kspa_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ptr_next   = size_m1[ADDR_W-1:0];
                            mem_raddr  = size_m1[ADDR_W-1:0];
                            state_next = kspa_pkg::S_MOD;
                        end
                    end

                    kspa_pkg::OP_LEX, kspa_pkg::OP_CRX:
                    begin
                        if (half_reg)
                        begin
                            if (size_empty)
                            begin
                                status_next = kspa_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ptr_next   = size_m1[ADDR_W-1:0];
                                mem_raddr  = size_m1[ADDR_W-1:0];
                                state_next = kspa_pkg::S_MOD;
                            end
                        end
                        else if (is_lex)
                        begin
                            // Lex bytes sit just below the contrelex run.
                            if (lex_reg == 7'd0)
                            begin
                                status_next = kspa_pkg::ST_OK;
                            end
                            else if (size_cw < need_cw)
                            begin
                                status_next = kspa_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ptr_next   = lex_pos_cw[ADDR_W-1:0];
                                mem_raddr  = lex_pos_cw[ADDR_W-1:0];
                                walk_next  = lex_reg;
                                state_next = kspa_pkg::S_WALK;
                            end
                        end
                        else
                        begin
                            if (crx_reg == 7'd0)
                            begin
                                status_next = kspa_pkg::ST_OK;
                            end
                            else if (size_cw < crx_cw)
                            begin
                                status_next = kspa_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ptr_next   = size_m1[ADDR_W-1:0];
                                mem_raddr  = size_m1[ADDR_W-1:0];
                                walk_next  = crx_reg;
                                state_next = kspa_pkg::S_WALK;
                            end
                        end
                    end

                    kspa_pkg::OP_READ:
                    begin
                        if (ridx_cw < size_cw)
                        begin
                            mem_raddr  = ridx_cw[ADDR_W-1:0];
                            state_next = kspa_pkg::S_MOD;
                        end
                        else
                        begin
                            status_next = kspa_pkg::ST_RANGE;
                        end
                    end

                    default:
                    begin
                        status_next = kspa_pkg::ST_RANGE;
                    end
                endcase
            end

            // Append the lex run of 255 bytes, then the contrelex run of zeros.
            kspa_pkg::S_FILL:
            begin
                mem_waddr = size_reg[ADDR_W-1:0];
                if (lex_reg != 7'd0)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = kspa_pkg::PAD_LEX;
                    size_next = size_p1;
                    lex_next  = lex_reg - 7'd1;
                end
                else if (crx_reg != 7'd0)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = kspa_pkg::PAD_CRX;
                    size_next = size_p1;
                    crx_next  = crx_reg - 7'd1;
                end
                else
                begin
                    state_next = kspa_pkg::S_DONE;
                end
            end

            // One read-modify-write of the last byte, or the read capture.
            kspa_pkg::S_MOD:
            begin
                state_next = kspa_pkg::S_DONE;
                case (op_reg)
                    kspa_pkg::OP_ADD:
                    begin
                        alu_func = kspa_pkg::ALU_OR;
                        mem_we   = 1'b1;
                        nbo_next = bit_end[2:0];
                        if (spill_needed)
                        begin
                            state_next = kspa_pkg::S_SPILL;
                        end
                    end

                    kspa_pkg::OP_LEX:
                    begin
                        alu_func = kspa_pkg::ALU_SUB16;
                        if (alu_flags.below16)
                        begin
                            status_next = kspa_pkg::ST_NO_LEX;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                        end
                    end

                    kspa_pkg::OP_CRX:
                    begin
                        alu_func = kspa_pkg::ALU_INC;
                        if (alu_flags.nib15)
                        begin
                            status_next = kspa_pkg::ST_NO_CRX;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                        end
                    end

                    default:
                    begin
                        rbyte_next = mem_rdata;
                    end
                endcase
            end

            // The spill byte is written fresh as a new key byte.
            kspa_pkg::S_SPILL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = size_reg[ADDR_W-1:0];
                mem_wdata  = alu_spill;
                size_next  = size_p1;
                state_next = kspa_pkg::S_DONE;
            end

            // Borrow or carry walk, one byte per cycle toward the key start.
            // Wrapping the byte gives 255 on a borrow from zero, zero on a
            // carry out of 255, so the written value is always the unit result.
            kspa_pkg::S_WALK:
            begin
                alu_func = is_lex ? kspa_pkg::ALU_DEC : kspa_pkg::ALU_INC;
                mem_we   = 1'b1;
                if (is_lex ? !alu_flags.zero : !alu_flags.ones)
                begin
                    state_next = kspa_pkg::S_DONE;
                end
                else if (walk_reg == 7'd1)
                begin
                    status_next = is_lex ? kspa_pkg::ST_NO_LEX : kspa_pkg::ST_NO_CRX;
                    state_next  = kspa_pkg::S_DONE;
                end
                else
                begin
                    walk_next = walk_reg - 7'd1;
                    ptr_next  = ptr_reg - ADDR_W'(1);
                    mem_raddr = ptr_reg - ADDR_W'(1);
                end
            end

            // Hand the result over once the result register is free.
            kspa_pkg::S_DONE:
            begin
                if (!ovalid_reg || results.ready)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = status_reg;
                    olen_next    = size_reg;
                    onbo_next    = nbo_reg;
                    orbyte_next  = rbyte_reg;
                    state_next   = kspa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = kspa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/sort_key_padding_assembler_unit.sv
// Sort key padding assembler: builds a byte-comparable key in a local store.
//
// Requests arrive on the items channel and each gives exactly one result on
// the results channel; both use valid/ready and move on an edge where both
// are high. A request is taken only while the sequencer is idle. The block
// then works through the key store, which has one write port and one
// registered read port, so it reads or writes one stored byte at a time.
// Clear, reject, add bits at offset zero and half-byte pad go straight to
// the result; add bits at nonzero offset, half-byte borrow/carry and read
// first read the last or indexed byte (add writes a spill byte on overflow);
// byte pad writes each lex and contrelex byte; byte borrow/carry writes
// each byte that the borrow or carry walks.
// The next request is taken in the cycle after the result is loaded.
// A finished result waits in an output register, so a stalled receiver does
// not stop the next request; only a second result waits for the first to go.
// Reset clears the key length and the result valid flag; the store contents
// are not cleared and bytes at or above the key length are never read.
module sort_key_padding_assembler_unit #(
    parameter int KEY_BYTES = kspa_pkg::KSPA_KEY_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    kspa_in_if.sink    items,
    kspa_out_if.source results
);

    localparam int ADDR_W = $clog2(KEY_BYTES);
    localparam int SIZE_W = $clog2(KEY_BYTES + 1);

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [7:0]           mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [7:0]           mem_rdata;
    kspa_pkg::alu_func_t  alu_func;
    logic [7:0]           alu_data;
    logic [2:0]           alu_offset;
    logic [7:0]           alu_result;
    logic [7:0]           alu_spill;
    kspa_pkg::alu_flags_t alu_flags;

    // Request sequencer and result register.
    kspa_seq #(
        .KEY_BYTES (KEY_BYTES),
        .ADDR_W    (ADDR_W),
        .SIZE_W    (SIZE_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .results    (results),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .alu_func   (alu_func),
        .alu_data   (alu_data),
        .alu_offset (alu_offset),
        .alu_result (alu_result),
        .alu_spill  (alu_spill),
        .alu_flags  (alu_flags)
    );

    // Shared byte unit.
    kspa_alu u_alu (
        .func   (alu_func),
        .stored (mem_rdata),
        .data   (alu_data),
        .offset (alu_offset),
        .result (alu_result),
        .spill  (alu_spill),
        .flags  (alu_flags)
    );

    // Key store.
    kspa_mem #(
        .DEPTH  (KEY_BYTES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
